// ===== rtl/core/ebc_pkg.sv =====
`default_nettype none

package ebc_pkg;

  localparam int COORD_BITS = 31;
  localparam int EDIT_BITS  = 32;
  localparam int CFG_BITS   = 17;

  // signed width for diagonal and gap differences
  localparam int DIFF_W = COORD_BITS + 2;
  // signed width for the unsaturated edit sum
  localparam int EDIT_SUM_W = (COORD_BITS + 4 > 35) ? COORD_BITS + 4 : 35;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_PW    = $clog2(OQ_DEPTH);

  localparam logic [15:0] DIAG_SLACK_RST = 16'd10;
  localparam logic [16:0] MAX_GAP_RST    = 17'd0;
  localparam logic [15:0] ERROR_RATE_RST = 16'd13107;

  typedef enum logic [1:0] {
    CFG_DIAG_SLACK = 2'd0,
    CFG_MAX_GAP    = 2'd1,
    CFG_ERROR_RATE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [COORD_BITS-1:0]       gen_start;
    logic [COORD_BITS-1:0]       gen_end;
    logic [COORD_BITS-1:0]       est_start;
    logic [COORD_BITS-1:0]       est_end;
    logic [COORD_BITS-1:0]       block_len;
    logic signed [EDIT_BITS-1:0] edit_dist;
    logic                        final_in;
  } blk_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]       out_gen_start;
    logic [COORD_BITS-1:0]       out_gen_end;
    logic [COORD_BITS-1:0]       out_est_start;
    logic [COORD_BITS-1:0]       out_est_end;
    logic [COORD_BITS-1:0]       out_len;
    logic signed [EDIT_BITS-1:0] out_edit;
    logic                        last_block;
  } blk_out_t;

  typedef struct packed {
    logic wr0;
    logic wr1;
  } oq_push_t;

endpackage

`default_nettype wire

// ===== rtl/core/ebc_out_fifo.sv =====
`default_nettype none

module ebc_out_fifo import ebc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire oq_push_t push_i,
  input  wire blk_out_t data0_i,
  input  wire blk_out_t data1_i,
  output logic          room2_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output blk_out_t      out_data_o
);

  blk_out_t       mem_q [OQ_DEPTH];
  logic [OQ_PW-1:0] wr_q, wr_d, rd_q, rd_d, wr_nx;
  logic [OQ_PW:0]   cnt_q, cnt_d;
  logic             pop;

  assign wr_nx       = wr_q + OQ_PW'(1);
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  assign room2_o     = (cnt_q <= (OQ_PW+1)'(OQ_DEPTH - 2));

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q + (OQ_PW+1)'(push_i.wr0) + (OQ_PW+1)'(push_i.wr1) - (OQ_PW+1)'(pop);
    if (push_i.wr1) begin
      wr_d = wr_q + OQ_PW'(2);
    end else if (push_i.wr0) begin
      wr_d = wr_nx;
    end
    if (pop) begin
      rd_d = rd_q + OQ_PW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.wr0) begin
      mem_q[wr_q] <= data0_i;
    end
    if (push_i.wr1) begin
      mem_q[wr_nx] <= data1_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (OQ_PW+1)'(OQ_DEPTH))
    else $error("output queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.wr1 |-> cnt_q <= (OQ_PW+1)'(OQ_DEPTH - 2))
    else $error("double write into a full output queue");

  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.wr1 |-> push_i.wr0)
    else $error("second slot written without the first");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/exon_block_coalescer_core.sv =====
`default_nettype none

// Channel   Dir  Handshake                    Payload
// in        in   in_valid_i / in_ready_o      in_data_i  (blk_in_t)
// out       out  out_valid_o / out_ready_i    out_data_o (blk_out_t)
// cfg       in   cfg_we_i                     cfg_idx_i, cfg_wdata_i
//
// One block per cycle while the queue has room: a transfer lands in the input
// register; from there the core compares it with the pending block, multiplies
// the gap by error_rate, updates the pending register and writes zero, one or
// two results into a four-entry output queue. A result passes through the input
// register and the output queue. The input register advances only while the
// queue has two free entries, so a stall on the output side backs up into in_ready_o.
// Reset clears the pending block and loads the register defaults.

module exon_block_coalescer_core import ebc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire blk_in_t             in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output blk_out_t                 out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [CFG_BITS-1:0] cfg_wdata_i
);

  localparam int CW = COORD_BITS;
  localparam int SW = EDIT_SUM_W;
  localparam logic signed [SW-1:0] EDIT_MAX = {{(SW-EDIT_BITS+1){1'b0}}, {(EDIT_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] EDIT_MIN = {{(SW-EDIT_BITS+1){1'b1}}, {(EDIT_BITS-1){1'b0}}};

  typedef struct packed {
    logic [CW-1:0]               gen_start;
    logic [CW-1:0]               gen_end;
    logic [CW-1:0]               est_start;
    logic [CW-1:0]               est_end;
    logic [CW-1:0]               len;
    logic signed [EDIT_BITS-1:0] edit;
  } pend_t;

  logic [15:0]          diag_slack_q, error_rate_q;
  logic [CFG_BITS-1:0]  max_gap_q;

  blk_in_t in_q;
  logic    in_vld_q;
  pend_t   pend_q, pend_d;
  logic    pend_vld_q, pend_vld_d;

  logic adv, room2, merge, emit_old;

  logic signed [DIFF_W-1:0] dnew, dold, ddiag, gap, max_gap_x;
  logic [DIFF_W-1:0]        ddiag_abs, gap_abs, corr_mag;
  logic [DIFF_W+15:0]       prod;
  logic signed [SW-1:0]     corr_s, edit_sum;
  logic signed [EDIT_BITS-1:0] edit_sat;
  logic [CW-1:0]            len_m;

  oq_push_t push;
  blk_out_t q_data0, q_data1, old_blk, new_blk;

  assign adv        = in_vld_q && room2;
  assign in_ready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diag_slack_q <= DIAG_SLACK_RST;
      max_gap_q    <= MAX_GAP_RST;
      error_rate_q <= ERROR_RATE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DIAG_SLACK: diag_slack_q <= cfg_wdata_i[15:0];
        CFG_MAX_GAP:    max_gap_q    <= cfg_wdata_i;
        CFG_ERROR_RATE: error_rate_q <= cfg_wdata_i[15:0];
        default:        ;
      endcase
    end
  end

  // merge test against the pending block
  always_comb begin
    dnew      = $signed({2'b00, in_q.est_start}) - $signed({2'b00, in_q.gen_start});
    dold      = $signed({2'b00, pend_q.est_end}) - $signed({2'b00, pend_q.gen_end});
    ddiag     = dnew - dold;
    ddiag_abs = ddiag[DIFF_W-1] ? DIFF_W'(-ddiag) : DIFF_W'(ddiag);
    gap       = $signed({2'b00, in_q.est_start}) - $signed({2'b00, pend_q.est_end})
              - $signed(DIFF_W'(1));
    gap_abs   = gap[DIFF_W-1] ? DIFF_W'(-gap) : DIFF_W'(gap);
    max_gap_x = $signed({{(DIFF_W-CFG_BITS){max_gap_q[CFG_BITS-1]}}, max_gap_q});
    merge     = pend_vld_q
              && (ddiag_abs <= {{(DIFF_W-16){1'b0}}, diag_slack_q})
              && (gap <= max_gap_x);
    emit_old  = pend_vld_q && !merge;
  end

  // gap correction and merged edit distance
  always_comb begin
    prod     = gap_abs * error_rate_q;
    corr_mag = prod[DIFF_W+15:16];
    corr_s   = $signed({{(SW-DIFF_W){1'b0}}, corr_mag});
    edit_sum = $signed({{(SW-EDIT_BITS){pend_q.edit[EDIT_BITS-1]}}, pend_q.edit})
             + $signed({{(SW-EDIT_BITS){in_q.edit_dist[EDIT_BITS-1]}}, in_q.edit_dist});
    // a negative gap adds its correction back
    if (gap[DIFF_W-1]) begin
      edit_sum = edit_sum + corr_s;
    end else begin
      edit_sum = edit_sum - corr_s;
    end
    if (edit_sum > EDIT_MAX) begin
      edit_sat = EDIT_MAX[EDIT_BITS-1:0];
    end else if (edit_sum < EDIT_MIN) begin
      edit_sat = EDIT_MIN[EDIT_BITS-1:0];
    end else begin
      edit_sat = edit_sum[EDIT_BITS-1:0];
    end
    len_m = in_q.est_end - pend_q.est_start + {{(CW-1){1'b0}}, 1'b1};
  end

  always_comb begin
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    if (adv) begin
      if (merge) begin
        pend_d.gen_end = in_q.gen_end;
        pend_d.est_end = in_q.est_end;
        pend_d.len     = len_m;
        pend_d.edit    = edit_sat;
      end else begin
        pend_d.gen_start = in_q.gen_start;
        pend_d.gen_end   = in_q.gen_end;
        pend_d.est_start = in_q.est_start;
        pend_d.est_end   = in_q.est_end;
        pend_d.len       = in_q.block_len;
        pend_d.edit      = in_q.edit_dist;
      end
      // flush drops the pending block
      pend_vld_d = !in_q.final_in;
    end
  end

  always_comb begin
    old_blk = '{out_gen_start: pend_q.gen_start, out_gen_end: pend_q.gen_end,
                out_est_start: pend_q.est_start, out_est_end: pend_q.est_end,
                out_len: pend_q.len, out_edit: pend_q.edit, last_block: 1'b0};
    new_blk = '{out_gen_start: pend_d.gen_start, out_gen_end: pend_d.gen_end,
                out_est_start: pend_d.est_start, out_est_end: pend_d.est_end,
                out_len: pend_d.len, out_edit: pend_d.edit, last_block: 1'b1};
    push.wr0 = adv && (emit_old || in_q.final_in);
    push.wr1 = adv && emit_old && in_q.final_in;
    q_data0  = emit_old ? old_blk : new_blk;
    q_data1  = new_blk;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    pend_q <= pend_d;
  end

  ebc_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data0_i     (q_data0),
    .data1_i     (q_data1),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_q.final_in |=> !pend_vld_q)
    else $error("pending block survived a flush");

  a_keep_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !in_q.final_in |=> pend_vld_q)
    else $error("pending block lost without a flush");

  a_merge_keeps_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && merge |=> pend_q.est_start == $past(pend_q.est_start)
                  && pend_q.gen_start == $past(pend_q.gen_start))
    else $error("merge moved the pending start");
`endif

endmodule

`default_nettype wire
